FILE: hw/rtl/plirc_pkg.sv
// ----------------------------------------------------------------------------
// plirc_pkg
// Shared types and codes for the positional list unit: request and result
// words, request and status codes, and the per-cell control word.
// ----------------------------------------------------------------------------
package plirc_pkg;

  localparam int unsigned PosW   = 5;
  localparam int unsigned ValW   = 32;
  localparam int unsigned CountW = 6;

  typedef enum logic [2:0] {
    REQ_APPEND = 3'd0,
    REQ_INSERT = 3'd1,
    REQ_REMOVE = 3'd2,
    REQ_COUNT  = 3'd3,
    REQ_READ   = 3'd4
  } req_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CMD_HOLD       = 2'd0,
    CMD_LOAD       = 2'd1,
    CMD_FROM_LOWER = 2'd2,
    CMD_FROM_UPPER = 2'd3
  } cell_cmd_e;

  typedef struct packed {
    cell_cmd_e cmd;
    logic      capture;
    logic      shift;
    logic      live;
  } cell_ctrl_t;

  typedef struct packed {
    logic [2:0]             req_type;
    logic [PosW-1:0]        position;
    logic signed [ValW-1:0] item_value;
  } req_word_t;

  typedef struct packed {
    status_e                status;
    logic [CountW-1:0]      match_count;
    logic signed [ValW-1:0] read_data;
    logic [CountW-1:0]      fill_level;
  } rsp_word_t;

endpackage

FILE: hw/rtl/plirc_cell.sv
// ----------------------------------------------------------------------------
// plirc_cell
// One list entry. Loads a new word or takes its neighbor's word on insert
// and remove; keeps a match flag that drains toward cell zero on count.
// ----------------------------------------------------------------------------
module plirc_cell #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  plirc_pkg::cell_ctrl_t   ctrl_i,
  input  logic [DATA_WIDTH-1:0]   load_data_i,
  input  logic [DATA_WIDTH-1:0]   lower_data_i,
  input  logic [DATA_WIDTH-1:0]   upper_data_i,
  input  logic                    upper_flag_i,
  output logic [DATA_WIDTH-1:0]   data_o,
  output logic                    flag_o
);
  import plirc_pkg::*;

  logic [DATA_WIDTH-1:0] data_q, data_d;
  logic                  flag_q, flag_d;

  always_comb begin
    case (ctrl_i.cmd)
      CMD_LOAD:       data_d = load_data_i;
      CMD_FROM_LOWER: data_d = lower_data_i;
      CMD_FROM_UPPER: data_d = upper_data_i;
      default:        data_d = data_q;
    endcase
  end

  always_comb begin
    if (ctrl_i.capture) begin
      flag_d = ctrl_i.live && (data_q == load_data_i);
    end else if (ctrl_i.shift) begin
      flag_d = upper_flag_i;
    end else begin
      flag_d = flag_q;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q <= 1'b0;
    end else begin
      flag_q <= flag_d;
    end
  end

  assign data_o = data_q;
  assign flag_o = flag_q;

endmodule

FILE: hw/rtl/positional_list_insert_remove_count_unit.sv
// ----------------------------------------------------------------------------
// positional_list_insert_remove_count_unit
// Ordered list of signed words held in a chain of cells, with append,
// insert, remove, match count and read requests.
// ----------------------------------------------------------------------------
// For append, insert, remove, read and unknown requests all cells shift or
// load in parallel and the result is registered, so the next request can be
// taken without waiting on the cells. A count request holds the input off
// until its answer is emitted: every cell compares against the target at
// once, then the match flags drain down the cell chain one per cycle into a
// counter, and the total is then handed to the output. Results leave through
// an output register backed by one skid word, so the next request is taken
// while a result still waits; a held skid word stalls the input.
// ----------------------------------------------------------------------------
module positional_list_insert_remove_count_unit #(
  parameter int unsigned DEPTH      = 32,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  plirc_pkg::req_word_t   in_word_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output plirc_pkg::rsp_word_t   out_word_o
);
  import plirc_pkg::*;

  localparam int unsigned FW   = $clog2(DEPTH + 1);
  localparam int unsigned CW   = (FW > PosW) ? FW : PosW;
  localparam int unsigned RD_N = (DEPTH < 32) ? DEPTH : 32;
  localparam int unsigned RDW  = $clog2(RD_N);

  typedef enum logic {
    S_RUN,
    S_COUNT
  } state_e;

  state_e          state_q, state_d;
  logic [FW-1:0]   fill_q, fill_d;
  logic [FW-1:0]   rem_q, rem_d;
  logic [FW-1:0]   cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;
  rsp_word_t       out_word_q, out_word_d;
  logic            skid_valid_q, skid_valid_d;
  rsp_word_t       skid_word_q, skid_word_d;

  logic                  accepted;
  logic [CW-1:0]         pos_ext, fill_ext;
  logic                  pos_ok, full;
  logic                  ok_append, ok_insert, ok_remove;
  logic                  is_append, is_insert, is_remove, is_count;
  logic [DATA_WIDTH-1:0] val_dw;
  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0]      cell_flag;
  cell_ctrl_t            cell_ctrl [DEPTH];
  logic                  shift_en;
  logic [DATA_WIDTH-1:0] rd_arr [RD_N];
  logic [DATA_WIDTH-1:0] rd_word;
  logic [ValW-1:0]       rd_ext;
  logic [ValW-1:0]       val_ext;
  rsp_word_t             res_word, cnt_word, emit_word;
  logic                  emit, count_done, out_free;

  assign accepted  = in_valid_i && !in_stall_o;
  assign in_stall_o = skid_valid_q || (state_q == S_COUNT);

  assign pos_ext  = CW'(in_word_i.position);
  assign fill_ext = CW'(fill_q);
  assign pos_ok   = pos_ext < fill_ext;
  assign full     = fill_q == FW'(DEPTH);

  assign is_append = in_word_i.req_type == REQ_APPEND;
  assign is_insert = in_word_i.req_type == REQ_INSERT;
  assign is_remove = in_word_i.req_type == REQ_REMOVE;
  assign is_count  = in_word_i.req_type == REQ_COUNT;

  assign ok_append = accepted && is_append && !full;
  assign ok_insert = accepted && is_insert && pos_ok && !full;
  assign ok_remove = accepted && is_remove && pos_ok;
  assign shift_en  = (state_q == S_COUNT) && (rem_q != '0);

  assign val_ext = in_word_i.item_value;

  generate
    if (DATA_WIDTH > ValW) begin : g_wide
      assign val_dw = {{(DATA_WIDTH - ValW){val_ext[ValW-1]}}, val_ext};
      assign rd_ext = rd_word[ValW-1:0];
    end else if (DATA_WIDTH == ValW) begin : g_same
      assign val_dw = val_ext;
      assign rd_ext = rd_word;
    end else begin : g_narrow
      assign val_dw = val_ext[DATA_WIDTH-1:0];
      assign rd_ext = {{(ValW - DATA_WIDTH){rd_word[DATA_WIDTH-1]}}, rd_word};
    end
  endgenerate

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] lower_data, upper_data;
    logic                  upper_flag;

    if (i == 0) begin : g_first
      assign lower_data = val_dw;
    end else begin : g_mid_lo
      assign lower_data = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign upper_data = cell_data[i];
      assign upper_flag = 1'b0;
    end else begin : g_mid_hi
      assign upper_data = cell_data[i+1];
      assign upper_flag = cell_flag[i+1];
    end

    always_comb begin
      cell_ctrl[i].cmd     = CMD_HOLD;
      cell_ctrl[i].capture = accepted && is_count;
      cell_ctrl[i].shift   = shift_en;
      cell_ctrl[i].live    = CW'(i) < fill_ext;
      if (ok_append && (CW'(i) == fill_ext)) begin
        cell_ctrl[i].cmd = CMD_LOAD;
      end else if (ok_insert && (CW'(i) == pos_ext)) begin
        cell_ctrl[i].cmd = CMD_LOAD;
      end else if (ok_insert && (CW'(i) > pos_ext)) begin
        cell_ctrl[i].cmd = CMD_FROM_LOWER;
      end else if (ok_remove && (CW'(i) >= pos_ext)) begin
        cell_ctrl[i].cmd = CMD_FROM_UPPER;
      end
    end

    plirc_cell #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (cell_ctrl[i]),
      .load_data_i  (val_dw),
      .lower_data_i (lower_data),
      .upper_data_i (upper_data),
      .upper_flag_i (upper_flag),
      .data_o       (cell_data[i]),
      .flag_o       (cell_flag[i])
    );
  end

  for (genvar j = 0; j < RD_N; j++) begin : g_rd
    assign rd_arr[j] = cell_data[j];
  end

  assign rd_word = rd_arr[in_word_i.position[RDW-1:0]];

  always_comb begin
    fill_d = fill_q;
    if (ok_append || ok_insert) begin
      fill_d = fill_q + FW'(1);
    end else if (ok_remove) begin
      fill_d = fill_q - FW'(1);
    end
  end

  always_comb begin
    res_word             = '0;
    res_word.status      = ST_OK;
    res_word.fill_level  = CountW'(fill_d);
    case (in_word_i.req_type)
      REQ_APPEND: begin
        if (full) res_word.status = ST_FULL;
      end
      REQ_INSERT: begin
        if (!pos_ok) begin
          res_word.status = ST_BADPOS;
        end else if (full) begin
          res_word.status = ST_FULL;
        end
      end
      REQ_REMOVE: begin
        if (!pos_ok) res_word.status = ST_BADPOS;
      end
      REQ_COUNT: begin
        res_word.status = ST_OK;
      end
      REQ_READ: begin
        if (!pos_ok) begin
          res_word.status = ST_BADPOS;
        end else begin
          res_word.read_data = rd_ext;
        end
      end
      default: begin
        res_word.status = ST_BADPOS;
      end
    endcase
  end

  always_comb begin
    cnt_word             = '0;
    cnt_word.status      = ST_OK;
    cnt_word.match_count = CountW'(cnt_q);
    cnt_word.fill_level  = CountW'(fill_q);
  end

  assign count_done = (state_q == S_COUNT) && (rem_q == '0);
  assign emit       = (accepted && !is_count) || count_done;
  assign emit_word  = count_done ? cnt_word : res_word;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d      = state_q;
    rem_d        = rem_q;
    cnt_d        = cnt_q;
    out_valid_d  = out_valid_q;
    out_word_d   = out_word_q;
    skid_valid_d = skid_valid_q;
    skid_word_d  = skid_word_q;

    if (accepted && is_count) begin
      state_d = S_COUNT;
      rem_d   = fill_q;
      cnt_d   = '0;
    end else if (count_done) begin
      state_d = S_RUN;
    end else if (shift_en) begin
      rem_d = rem_q - FW'(1);
      cnt_d = cnt_q + FW'(cell_flag[0]);
    end

    if (out_free) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_word_d   = skid_word_q;
        skid_valid_d = emit;
        if (emit) skid_word_d = emit_word;
      end else begin
        out_valid_d = emit;
        if (emit) out_word_d = emit_word;
      end
    end else if (emit) begin
      skid_valid_d = 1'b1;
      skid_word_d  = emit_word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_RUN;
      fill_q       <= '0;
      rem_q        <= '0;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
      out_word_q   <= '0;
      skid_valid_q <= 1'b0;
      skid_word_q  <= '0;
    end else begin
      state_q      <= state_d;
      fill_q       <= fill_d;
      rem_q        <= rem_d;
      cnt_q        <= cnt_d;
      out_valid_q  <= out_valid_d;
      out_word_q   <= out_word_d;
      skid_valid_q <= skid_valid_d;
      skid_word_q  <= skid_word_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(DEPTH))
    else $error("fill above depth");

  a_count_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_COUNT) |-> in_stall_o)
    else $error("request accepted during count");

  a_skid_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid word held with empty output register");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_COUNT) |-> (rem_q <= fill_q))
    else $error("count drain longer than fill");

  a_result_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accepted && !is_count) |=> out_valid_q)
    else $error("no result after single-cycle request");
`endif

endmodule
